// ----- design/rcf_pkg.sv -----
// Package for the rendezvous channel FIFO: request and status codes,
// the controller state type and the default sizes.
// No dependencies; used by rendezvous_channel_fifo.
package rcf_pkg;

    // Default sizes for the top-level parameters
    localparam int DEPTH_DEF           = 16;
    localparam int DATA_WIDTH_DEF      = 32;
    localparam int REQUESTER_COUNT_DEF = 16;

    // Capacity register: five bits, reset to sixteen entries
    localparam int             CFG_W      = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Request codes
    localparam int         OP_W        = 3;
    localparam logic [2:0] OP_SEND     = 3'd0;
    localparam logic [2:0] OP_TRY_SEND = 3'd1;
    localparam logic [2:0] OP_RECV     = 3'd2;
    localparam logic [2:0] OP_TRY_RECV = 3'd3;
    localparam logic [2:0] OP_CLOSE    = 3'd4;

    // Completion status codes
    localparam int         STAT_W       = 2;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CLOSED  = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;
    localparam logic [1:0] STAT_BUSY    = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } rcf_state_t;

endpackage

// ----- design/rcf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced for the ring store of the channel.
module rcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rendezvous_channel_fifo.sv -----
// Channel         Direction  Handshake        Payload
// request  (s_)   in         s_valid/s_ready  operation, requester, send_value
// result   (m_)   out        m_valid/m_ready  completed_requester, status,
//                                             received_value, held_items, last
// config          in         cfg_wr_en        cfg_wr_data (capacity)
//
// A request passes accept (ring read issued), then execute (read data back,
// ring write, state update); the registered ring RAM read sets this split.
// Results (zero, one or two per request) sit in a two-entry buffer; the next
// request executes only once that buffer has drained.
// Reset (aresetn low, synchronous) clears control state and capacity to 16;
// ring contents are not cleared and need no clearing pass.
// Depends on rcf_pkg and rcf_ram.
module rendezvous_channel_fifo #(
    parameter int DEPTH           = rcf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH      = rcf_pkg::DATA_WIDTH_DEF,
    parameter int REQUESTER_COUNT = rcf_pkg::REQUESTER_COUNT_DEF,
    localparam int TAG_W = (REQUESTER_COUNT > 1) ? $clog2(REQUESTER_COUNT) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [rcf_pkg::CFG_W-1:0] cfg_wr_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [rcf_pkg::OP_W-1:0]  s_operation,
    input  logic [TAG_W-1:0]          s_requester,
    input  logic [DATA_WIDTH-1:0]     s_send_value,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [TAG_W-1:0]          m_completed_requester,
    output logic [rcf_pkg::STAT_W-1:0] m_status,
    output logic [DATA_WIDTH-1:0]     m_received_value,
    output logic [CNT_W-1:0]          m_held_items,
    output logic                      m_last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > rcf_pkg::CFG_W) ? CNT_W : rcf_pkg::CFG_W;

    typedef struct packed {
        logic [TAG_W-1:0]           tag;
        logic [rcf_pkg::STAT_W-1:0] status;
        logic [DATA_WIDTH-1:0]      value;
        logic [CNT_W-1:0]           held;
        logic                       last;
    } res_t;

    rcf_pkg::rcf_state_t state_reg, state_next;

    logic [rcf_pkg::CFG_W-1:0] capacity_reg;
    logic [IDX_W-1:0]          read_index_reg, read_index_next;
    logic [IDX_W-1:0]          write_index_reg, write_index_next;
    logic [CNT_W-1:0]          item_count_reg, item_count_next;
    logic                      closed_reg, closed_next;
    logic                      sender_parked_reg, sender_parked_next;
    logic [TAG_W-1:0]          sender_tag_reg, sender_tag_next;
    logic [DATA_WIDTH-1:0]     sender_value_reg, sender_value_next;
    logic                      receiver_parked_reg, receiver_parked_next;
    logic [TAG_W-1:0]          receiver_tag_reg, receiver_tag_next;

    logic [rcf_pkg::OP_W-1:0]  req_op_reg, req_op_next;
    logic [TAG_W-1:0]          req_tag_reg, req_tag_next;
    logic [DATA_WIDTH-1:0]     req_value_reg, req_value_next;

    res_t       res0_reg, res0_next;
    res_t       res1_reg, res1_next;
    logic [1:0] res_cnt_reg, res_cnt_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0] cap_eff;
    logic             ring_full;
    logic             ring_empty;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        return (CNT_W'(idx) < cap) ? idx : '0;
    endfunction

    function automatic logic [IDX_W-1:0] step_slot(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt < cap) ? IDX_W'(nxt) : '0;
    endfunction

    // Clamp capacity to the ring depth
    assign cap_eff = (CMP_W'(capacity_reg) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                           : CNT_W'(capacity_reg);

    assign ring_full  = (cap_eff != '0) ? (item_count_reg >= cap_eff) : !receiver_parked_reg;
    assign ring_empty = (cap_eff != '0) ? (item_count_reg == '0) : !sender_parked_reg;

    rcf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg        <= rcf_pkg::CAP_RESET;
            read_index_reg      <= '0;
            write_index_reg     <= '0;
            item_count_reg      <= '0;
            closed_reg          <= 1'b0;
            sender_parked_reg   <= 1'b0;
            sender_tag_reg      <= '0;
            sender_value_reg    <= '0;
            receiver_parked_reg <= 1'b0;
            receiver_tag_reg    <= '0;
            res_cnt_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            read_index_reg      <= read_index_next;
            write_index_reg     <= write_index_next;
            item_count_reg      <= item_count_next;
            closed_reg          <= closed_next;
            sender_parked_reg   <= sender_parked_next;
            sender_tag_reg      <= sender_tag_next;
            sender_value_reg    <= sender_value_next;
            receiver_parked_reg <= receiver_parked_next;
            receiver_tag_reg    <= receiver_tag_next;
            res_cnt_reg         <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_op_reg    <= req_op_next;
        req_tag_reg   <= req_tag_next;
        req_value_reg <= req_value_next;
        res0_reg      <= res0_next;
        res1_reg      <= res1_next;
    end

    always_comb begin
        res_t       ra;
        res_t       rb;
        logic [1:0] n;
        logic       try_op;
        logic [IDX_W-1:0] ri_step;

        state_next           = state_reg;
        read_index_next      = read_index_reg;
        write_index_next     = write_index_reg;
        item_count_next      = item_count_reg;
        closed_next          = closed_reg;
        sender_parked_next   = sender_parked_reg;
        sender_tag_next      = sender_tag_reg;
        sender_value_next    = sender_value_reg;
        receiver_parked_next = receiver_parked_reg;
        receiver_tag_next    = receiver_tag_reg;
        req_op_next          = req_op_reg;
        req_tag_next         = req_tag_reg;
        req_value_next       = req_value_reg;
        res0_next            = res0_reg;
        res1_next            = res1_reg;
        res_cnt_next         = res_cnt_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_of(write_index_reg, cap_eff);
        ram_wdata = req_value_reg;
        ram_re    = 1'b0;
        ram_raddr = slot_of(read_index_reg, cap_eff);

        ra      = '0;
        rb      = '0;
        n       = 2'd0;
        try_op  = 1'b0;
        ri_step = step_slot(read_index_reg, cap_eff);

        s_ready = (state_reg == rcf_pkg::ST_IDLE);

        // Drain the head result
        if (m_valid && m_ready) begin
            res0_next    = res1_reg;
            res_cnt_next = res_cnt_reg - 2'd1;
        end

        unique case (state_reg)
            rcf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_op_next    = s_operation;
                    req_tag_next   = s_requester;
                    req_value_next = s_send_value;
                    ram_re         = 1'b1;
                    state_next     = rcf_pkg::ST_EXEC;
                end
            end
            rcf_pkg::ST_EXEC: begin
                // Hold until the result buffer has drained
                if (res_cnt_reg == 2'd0) begin
                    state_next = rcf_pkg::ST_IDLE;
                    unique case (req_op_reg)
                        rcf_pkg::OP_SEND, rcf_pkg::OP_TRY_SEND: begin
                            try_op = (req_op_reg == rcf_pkg::OP_TRY_SEND);
                            if (closed_reg) begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_CLOSED, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else if (try_op && ring_full) begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_REFUSED, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else if (sender_parked_reg) begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_BUSY, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else if (receiver_parked_reg) begin
                                // Hand the value straight to the parked receiver
                                receiver_parked_next = 1'b0;
                                ra = '{receiver_tag_reg, rcf_pkg::STAT_OK, req_value_reg,
                                       '0, 1'b0};
                                rb = '{req_tag_reg, rcf_pkg::STAT_OK, '0, '0, 1'b0};
                                n  = 2'd2;
                            end else if (item_count_reg < cap_eff) begin
                                ram_we           = 1'b1;
                                write_index_next = step_slot(write_index_reg, cap_eff);
                                item_count_next  = item_count_reg + CNT_W'(1);
                                ra = '{req_tag_reg, rcf_pkg::STAT_OK, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else begin
                                sender_parked_next = 1'b1;
                                sender_tag_next    = req_tag_reg;
                                sender_value_next  = req_value_reg;
                            end
                        end
                        rcf_pkg::OP_RECV, rcf_pkg::OP_TRY_RECV: begin
                            try_op = (req_op_reg == rcf_pkg::OP_TRY_RECV);
                            if (closed_reg) begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_CLOSED, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else if (try_op && ring_empty) begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_REFUSED, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else if (receiver_parked_reg) begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_BUSY, '0, '0, 1'b0};
                                n  = 2'd1;
                            end else if (sender_parked_reg) begin
                                sender_parked_next = 1'b0;
                                ra = '{sender_tag_reg, rcf_pkg::STAT_OK, '0, '0, 1'b0};
                                if (item_count_reg != '0) begin
                                    // Pop the oldest and drop the sender's value in its slot
                                    ram_we           = 1'b1;
                                    ram_waddr        = slot_of(read_index_reg, cap_eff);
                                    ram_wdata        = sender_value_reg;
                                    read_index_next  = ri_step;
                                    write_index_next = ri_step;
                                    rb = '{req_tag_reg, rcf_pkg::STAT_OK, ram_rdata,
                                           '0, 1'b0};
                                end else begin
                                    rb = '{req_tag_reg, rcf_pkg::STAT_OK, sender_value_reg,
                                           '0, 1'b0};
                                end
                                n = 2'd2;
                            end else if (item_count_reg != '0) begin
                                read_index_next = ri_step;
                                item_count_next = item_count_reg - CNT_W'(1);
                                ra = '{req_tag_reg, rcf_pkg::STAT_OK, ram_rdata, '0, 1'b0};
                                n  = 2'd1;
                            end else begin
                                receiver_parked_next = 1'b1;
                                receiver_tag_next    = req_tag_reg;
                            end
                        end
                        rcf_pkg::OP_CLOSE: begin
                            closed_next = 1'b1;
                            // At most one side can be parked
                            if (sender_parked_reg) begin
                                sender_parked_next = 1'b0;
                                ra = '{sender_tag_reg, rcf_pkg::STAT_CLOSED, '0, '0, 1'b0};
                                rb = '{req_tag_reg, rcf_pkg::STAT_OK, '0, '0, 1'b0};
                                n  = 2'd2;
                            end else if (receiver_parked_reg) begin
                                receiver_parked_next = 1'b0;
                                ra = '{receiver_tag_reg, rcf_pkg::STAT_CLOSED, '0, '0, 1'b0};
                                rb = '{req_tag_reg, rcf_pkg::STAT_OK, '0, '0, 1'b0};
                                n  = 2'd2;
                            end else begin
                                ra = '{req_tag_reg, rcf_pkg::STAT_OK, '0, '0, 1'b0};
                                n  = 2'd1;
                            end
                        end
                        default: begin
                            // Unknown request: drop it
                        end
                    endcase
                    ra.held = item_count_next;
                    rb.held = item_count_next;
                    ra.last = (n == 2'd1);
                    rb.last = 1'b1;
                    if (n != 2'd0) begin
                        res0_next    = ra;
                        res1_next    = rb;
                        res_cnt_next = n;
                    end
                end
            end
            default: begin
                state_next = rcf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid               = (res_cnt_reg != 2'd0);
    assign m_completed_requester = res0_reg.tag;
    assign m_status              = res0_reg.status;
    assign m_received_value      = res0_reg.value;
    assign m_held_items          = res0_reg.held;
    assign m_last                = res0_reg.last;

`ifndef SYNTHESIS
    a_one_side_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sender_parked_reg && receiver_parked_reg))
        else $error("sender and receiver parked together");

    a_closed_no_waiter: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |-> (!sender_parked_reg && !receiver_parked_reg))
        else $error("waiter still parked on a closed channel");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        item_count_reg <= CNT_W'(DEPTH))
        else $error("item count beyond ring depth");

    a_last_marks_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (res_cnt_reg == 2'd1)))
        else $error("last flag does not mark the final result");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == rcf_pkg::ST_EXEC))
        else $error("accepted request not executed");
`endif

endmodule
